@@ design/ssa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_pkg: shared types and constants of the swap slot allocator
// Field widths, opcodes, the slot table row and the controller/datapath links.
// ----------------------------------------------------------------------------
package ssa_pkg;

  // Field widths
  localparam int OPCODE_W = 2;
  localparam int PAGE_W   = 20;
  localparam int TID_W    = 16;
  localparam int SIDX_W   = 10;
  localparam int SECTOR_W = 13;
  localparam int SWAP_W   = 14;

  // Default sizing
  localparam int DEF_NUM_SLOTS        = 1024;
  localparam int DEF_SECTORS_PER_SLOT = 8;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_PULL  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_CLEAN = 2'd3;

  // One entry of the slot table
  typedef struct packed {
    logic              busy;
    logic [PAGE_W-1:0] page;
    logic [TID_W-1:0]  tid;
  } ssa_row_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // latch the transaction, start slot read
    logic alloc;       // take a slot from the stack or create one
    logic free_apply;  // release the addressed slot if occupied
    logic scan_step;   // one step of the table scan
    logic scan_end;    // scan ran off the end of the created slots
    logic load_out;    // move the result into the output register
  } ssa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic op_is_pull;
    logic hit;
    logic scan_done;
    logic out_free;
  } ssa_stat_t;

endpackage

@@ design/ssa_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_datapath: slot table, free stack, counters and result registers
// Executes the controller's commands; the slot table and free stack are
// simple dual-port memories with registered read data.
// ----------------------------------------------------------------------------
module ssa_datapath
  import ssa_pkg::*;
#(
  parameter int NUM_SLOTS        = DEF_NUM_SLOTS,
  parameter int SECTORS_PER_SLOT = DEF_SECTORS_PER_SLOT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [SWAP_W-1:0]   cfg_data,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [PAGE_W-1:0]   page_id,
  input  logic [TID_W-1:0]    owner_tid,
  input  logic [SIDX_W-1:0]   slot_index,
  input  ssa_cmd_t            cmd,
  output ssa_stat_t           stat,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                op_ok,
  output logic [SECTOR_W-1:0] sector
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int CW    = (CNT_W > SIDX_W) ? CNT_W : SIDX_W;

  // Registers
  logic [SWAP_W-1:0]   swap_sectors;
  logic [OPCODE_W-1:0] op_q;
  logic [PAGE_W-1:0]   page_q;
  logic [TID_W-1:0]    tid_q;
  logic [SIDX_W-1:0]   sidx_q;
  logic [CNT_W-1:0]    slots_created;
  logic [CNT_W-1:0]    free_count;
  logic [CNT_W-1:0]    scan_cnt;
  logic                pend;
  logic [IDX_W-1:0]    pend_idx;
  logic                res_ok;
  logic [SECTOR_W-1:0] res_sector;

  // Memories
  ssa_row_t            slot_mem [NUM_SLOTS];
  logic [IDX_W-1:0]    stack_mem [NUM_SLOTS];
  ssa_row_t            rd_row;
  logic [IDX_W-1:0]    stack_top;

  // Combinational signals
  logic             issue;
  logic [IDX_W-1:0] scan_addr;
  logic [IDX_W-1:0] free_addr;
  logic             match;
  logic             hit;
  logic             free_ok;
  logic             release_en;
  logic [IDX_W-1:0] release_idx;
  logic             from_stack;
  logic             create_ok;
  logic [IDX_W-1:0] alloc_idx;
  logic             alloc_got;
  logic [IDX_W-1:0] sec_idx;
  logic [31:0]      sec_prod;
  logic [SECTOR_W-1:0] sec_val;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  ssa_row_t         wr_row;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             push_en;

  // Scan addressing: only created slots can ever be occupied
  assign issue     = scan_cnt < slots_created;
  assign scan_addr = scan_cnt[IDX_W-1:0];
  assign free_addr = IDX_W'(CW'(sidx_q));

  // Compare stage of the scan and the free check
  assign match   = (op_q == OP_PULL) ? (rd_row.page == page_q) : (rd_row.tid == tid_q);
  assign hit     = pend & rd_row.busy & match;
  assign free_ok = (CW'(sidx_q) < CW'(slots_created)) & rd_row.busy;

  assign release_en  = (cmd.scan_step & hit) | (cmd.free_apply & free_ok);
  assign release_idx = cmd.free_apply ? free_addr : pend_idx;
  assign push_en     = release_en & (free_count < CNT_W'(NUM_SLOTS));

  // Allocation choice: reuse from the stack first, else create
  assign from_stack = free_count != '0;
  assign create_ok  = (slots_created < CNT_W'(NUM_SLOTS)) &&
                      ((32'(slots_created) * 32'(SECTORS_PER_SLOT)) < 32'(swap_sectors));
  assign alloc_idx  = from_stack ? stack_top : slots_created[IDX_W-1:0];
  assign alloc_got  = from_stack | create_ok;

  // First sector of a slot, kept to the sector field width
  assign sec_idx  = cmd.alloc ? alloc_idx : pend_idx;
  assign sec_prod = 32'(sec_idx) * 32'(SECTORS_PER_SLOT);
  assign sec_val  = sec_prod[SECTOR_W-1:0];

  // Slot table ports
  assign wr_en   = (cmd.alloc & alloc_got) | release_en;
  assign wr_addr = cmd.alloc ? alloc_idx : release_idx;
  always_comb begin
    if (cmd.alloc) begin
      wr_row = '{busy: 1'b1, page: page_q, tid: tid_q};
    end else begin
      wr_row = '{busy: 1'b0, page: rd_row.page, tid: rd_row.tid};
    end
  end
  assign rd_en   = cmd.capture | (cmd.scan_step & issue);
  assign rd_addr = cmd.capture ? IDX_W'(CW'(slot_index)) : scan_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row <= slot_mem[rd_addr];
    end
  end

  // Free stack: read the top, push at the fill count
  always_ff @(posedge clk) begin
    if (push_en) begin
      stack_mem[free_count[IDX_W-1:0]] <= release_idx;
    end
    if (from_stack) begin
      stack_top <= stack_mem[IDX_W'(free_count - CNT_W'(1))];
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      swap_sectors <= '0;
    end else if (cfg_we) begin
      swap_sectors <= cfg_data;
    end
  end

  // Transaction capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= opcode;
      page_q <= page_id;
      tid_q  <= owner_tid;
      sidx_q <= slot_index;
    end
  end

  // Counters
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_created <= '0;
      free_count    <= '0;
    end else begin
      if (cmd.alloc && from_stack) begin
        free_count <= free_count - CNT_W'(1);
      end else if (push_en) begin
        free_count <= free_count + CNT_W'(1);
      end
      if (cmd.alloc && !from_stack && create_ok) begin
        slots_created <= slots_created + CNT_W'(1);
      end
    end
  end

  // Scan pointer and compare-stage tag
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
      pend     <= 1'b0;
    end else if (cmd.capture) begin
      scan_cnt <= '0;
      pend     <= 1'b0;
    end else if (cmd.scan_step) begin
      pend <= issue;
      if (issue) begin
        scan_cnt <= scan_cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && issue) begin
      pend_idx <= scan_addr;
    end
  end

  // Result staging
  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      res_ok     <= alloc_got;
      res_sector <= alloc_got ? sec_val : '0;
    end else if (cmd.scan_step && hit && (op_q == OP_PULL)) begin
      res_ok     <= 1'b1;
      res_sector <= sec_val;
    end else if (cmd.scan_end) begin
      res_ok     <= op_q != OP_PULL;
      res_sector <= '0;
    end else if (cmd.free_apply) begin
      res_ok     <= 1'b1;
      res_sector <= '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      op_ok  <= res_ok;
      sector <= res_sector;
    end
  end

  // Status
  assign stat.op_is_pull = op_q == OP_PULL;
  assign stat.hit        = hit;
  assign stat.scan_done  = !issue && !pend;
  assign stat.out_free   = !out_valid || out_ready;

  // Assertions
  a_free_le_created: assert property (@(posedge clk) disable iff (rst)
    free_count <= slots_created)
    else $error("free stack holds more slots than were created");

  a_created_bound: assert property (@(posedge clk) disable iff (rst)
    slots_created <= CNT_W'(NUM_SLOTS))
    else $error("created slot count beyond table size");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  a_release_push: assert property (@(posedge clk) disable iff (rst)
    release_en |=> free_count == CNT_W'($past(free_count) + CNT_W'(1)))
    else $error("released slot not pushed onto the free stack");

  a_alloc_pop: assert property (@(posedge clk) disable iff (rst)
    (cmd.alloc && from_stack) |=> free_count == CNT_W'($past(free_count) - CNT_W'(1)))
    else $error("reused slot not popped from the free stack");

endmodule

@@ design/ssa_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_ctrl: transaction sequencer of the swap slot allocator
// Accepts one transaction at a time, steps the datapath through allocate,
// free or table scan, then hands the result to the output register.
// ----------------------------------------------------------------------------
module ssa_ctrl
  import ssa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OPCODE_W-1:0] opcode,
  input  ssa_stat_t           stat,
  output ssa_cmd_t            cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_FREE  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = state == S_IDLE;

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (opcode)
            OP_ALLOC: state_next = S_ALLOC;
            OP_FREE:  state_next = S_FREE;
            OP_PULL:  state_next = S_SCAN;
            OP_CLEAN: state_next = S_SCAN;
          endcase
        end
      end
      S_ALLOC: begin
        cmd.alloc  = 1'b1;
        state_next = S_RESP;
      end
      S_FREE: begin
        cmd.free_apply = 1'b1;
        state_next     = S_RESP;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.op_is_pull && stat.hit) begin
          state_next = S_RESP;
        end else if (stat.scan_done) begin
          cmd.scan_end = 1'b1;
          state_next   = S_RESP;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ design/swap_slot_allocator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swap_slot_allocator_core: swap slot allocator with LIFO free list
// Allocate, pull, free and clean over a table of swap slots.
// ----------------------------------------------------------------------------
// One transaction is in work at a time. Allocate and free go through their own
// state and then the response state to the result being offered; pull and clean
// scan the slot table through its single read port, one slot a cycle, over the
// slots created so far (pull stops at the first match). A finished result sits
// in an output register, so the next transaction can be accepted while it
// waits. No clearing pass follows reset: slots at or above the created count
// read as free. swap_sectors is written through cfg_we and cfg_data; the user
// must write it only while the block is idle, the block does not enforce it.
module swap_slot_allocator_core
  import ssa_pkg::*;
#(
  parameter int NUM_SLOTS        = DEF_NUM_SLOTS,
  parameter int SECTORS_PER_SLOT = DEF_SECTORS_PER_SLOT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [SWAP_W-1:0]   cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [PAGE_W-1:0]   page_id,
  input  logic [TID_W-1:0]    owner_tid,
  input  logic [SIDX_W-1:0]   slot_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                op_ok,
  output logic [SECTOR_W-1:0] sector
);

  ssa_cmd_t  cmd;
  ssa_stat_t stat;

  // Sequencer
  ssa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Slot table, free stack and result path
  ssa_datapath #(
    .NUM_SLOTS        (NUM_SLOTS),
    .SECTORS_PER_SLOT (SECTORS_PER_SLOT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .opcode     (opcode),
    .page_id    (page_id),
    .owner_tid  (owner_tid),
    .slot_index (slot_index),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .op_ok      (op_ok),
    .sector     (sector)
  );

endmodule

@@ bench/swap_slot_allocator_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swap_slot_allocator_core_test: self-checking bench for the swap slot allocator
// Sends allocate, pull, free and clean transactions with random idling on both
// channels. A behavioural copy of the slot table and free stack predicts each
// result, and every result is compared in order with its prediction.
// ----------------------------------------------------------------------------
module swap_slot_allocator_core_test;
  import ssa_pkg::*;

  localparam int NUM_SLOTS        = DEF_NUM_SLOTS;
  localparam int SECTORS_PER_SLOT = DEF_SECTORS_PER_SLOT;
  localparam int STALL_LIMIT      = 6000;
  localparam int REPORT_LIMIT     = 10;
  localparam int LARGE_FILL       = 200;

  typedef struct packed {
    logic                ok;
    logic [SECTOR_W-1:0] sector;
  } outcome_t;

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                cfg_we     = 1'b0;
  logic [SWAP_W-1:0]   cfg_data   = '0;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  logic [OPCODE_W-1:0] opcode     = OP_ALLOC;
  logic [PAGE_W-1:0]   page_id    = '0;
  logic [TID_W-1:0]    owner_tid  = '0;
  logic [SIDX_W-1:0]   slot_index = '0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  logic                op_ok;
  logic [SECTOR_W-1:0] sector;

  // Behavioural copy of the allocator state
  logic              held          [NUM_SLOTS];
  logic [PAGE_W-1:0] held_page     [NUM_SLOTS];
  logic [TID_W-1:0]  held_task     [NUM_SLOTS];
  int                recycle_stack [NUM_SLOTS];
  int                recycle_depth = 0;
  int                made_count    = 0;
  int                partition_sectors = 0;

  outcome_t          awaited_outcomes[$];
  int                mismatch_count = 0;
  int                quiet_cycles   = 0;
  bit                steady         = 1'b0;  // no idling on either side
  logic [PAGE_W-1:0] page_pool [16];
  logic [TID_W-1:0]  task_pool [6];

  swap_slot_allocator_core #(
    .NUM_SLOTS        (NUM_SLOTS),
    .SECTORS_PER_SLOT (SECTORS_PER_SLOT)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .page_id    (page_id),
    .owner_tid  (owner_tid),
    .slot_index (slot_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .op_ok      (op_ok),
    .sector     (sector)
  );

  // Clock
  initial begin
    forever #10 clk = ~clk;
  end

  // First sector of a slot, kept to the port width
  function automatic logic [SECTOR_W-1:0] slot_sector(int idx);
    int raw;
    raw = idx * SECTORS_PER_SLOT;
    return raw[SECTOR_W-1:0];
  endfunction

  // Release a slot if it is occupied and push it on the free stack
  function automatic void drop_slot(int idx);
    if (idx >= NUM_SLOTS || !held[idx]) return;
    held[idx] = 1'b0;
    if (recycle_depth < NUM_SLOTS) begin
      recycle_stack[recycle_depth] = idx;
      recycle_depth++;
    end
  endfunction

  // Apply one transaction to the model and return the result it gives
  function automatic outcome_t book_outcome(logic [OPCODE_W-1:0] op,
                                            logic [PAGE_W-1:0] page,
                                            logic [TID_W-1:0] tid,
                                            logic [SIDX_W-1:0] sidx);
    outcome_t res;
    int       idx;
    bit       got;
    res.ok     = 1'b1;
    res.sector = '0;
    idx        = 0;
    got        = 1'b0;
    case (op)
      OP_ALLOC: begin
        // free stack first, then a new slot while the partition has room
        if (recycle_depth > 0) begin
          recycle_depth--;
          idx = recycle_stack[recycle_depth];
          got = 1'b1;
        end else if (made_count < NUM_SLOTS &&
                     made_count * SECTORS_PER_SLOT < partition_sectors) begin
          idx = made_count;
          made_count++;
          got = 1'b1;
        end
        if (got) begin
          held[idx]      = 1'b1;
          held_page[idx] = page;
          held_task[idx] = tid;
          res.sector     = slot_sector(idx);
        end else begin
          res.ok = 1'b0;
        end
      end
      OP_PULL: begin
        // lowest occupied slot holding the page wins
        res.ok = 1'b0;
        for (int i = 0; i < NUM_SLOTS && !res.ok; i++) begin
          if (held[i] && held_page[i] == page) begin
            res.ok     = 1'b1;
            res.sector = slot_sector(i);
            drop_slot(i);
          end
        end
      end
      OP_FREE: drop_slot(int'(sidx));
      default: begin
        // clean: ascending order, so the highest index is reused first
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (held[i] && held_task[i] == tid) drop_slot(i);
        end
      end
    endcase
    return res;
  endfunction

  // Send one transaction and book its expected result on acceptance
  task automatic issue_request(input logic [OPCODE_W-1:0] op,
                               input logic [PAGE_W-1:0] page,
                               input logic [TID_W-1:0] tid,
                               input logic [SIDX_W-1:0] sidx);
    if (!steady && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    page_id    <= page;
    owner_tid  <= tid;
    slot_index <= sidx;
    do @(posedge clk); while (!in_ready);
    awaited_outcomes.push_back(book_outcome(op, page, tid, sidx));
  endtask

  // Write the partition size once the block has drained
  task automatic write_partition_size(input int value);
    in_valid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value[SWAP_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    partition_sectors = value & 16'h3FFF;
  endtask

  // Zero-sized partition: nothing can be created, every lookup misses
  task automatic test_empty_partition();
    write_partition_size(0);
    issue_request(OP_ALLOC, 20'h12345, 16'h0001, '0);
    issue_request(OP_PULL,  20'h12345, '0, '0);
    issue_request(OP_FREE,  '0, '0, 10'd0);
    issue_request(OP_FREE,  '0, '0, 10'h3FF);
    issue_request(OP_CLEAN, '0, 16'hFFFF, '0);
  endtask

  // Three-slot partition: limit, duplicates, misses, LIFO reuse, clean order
  task automatic test_directed_ops();
    write_partition_size(17);
    issue_request(OP_ALLOC, 20'h00000, 16'h0000, '0);
    issue_request(OP_ALLOC, 20'hFFFFF, 16'hFFFF, '0);
    issue_request(OP_ALLOC, 20'h00000, 16'h0005, '0);  // same page again
    issue_request(OP_ALLOC, 20'h00001, 16'h0005, '0);  // partition full
    issue_request(OP_PULL,  20'h00000, '0, '0);
    issue_request(OP_PULL,  20'h00000, '0, '0);
    issue_request(OP_PULL,  20'h00000, '0, '0);        // miss
    issue_request(OP_FREE,  '0, '0, 10'd1);
    issue_request(OP_FREE,  '0, '0, 10'd1);            // already idle
    issue_request(OP_ALLOC, 20'h00003, 16'h0007, '0);
    issue_request(OP_ALLOC, 20'h00004, 16'h0007, '0);
    issue_request(OP_ALLOC, 20'h00005, 16'h0007, '0);
    issue_request(OP_CLEAN, '0, 16'h0007, '0);
    issue_request(OP_ALLOC, 20'h00006, 16'h0008, '0);
    issue_request(OP_ALLOC, 20'h00007, 16'h0008, '0);
    issue_request(OP_PULL,  20'hFFFFF, '0, '0);
    issue_request(OP_FREE,  '0, '0, 10'h3FF);          // never created
  endtask

  // Random traffic over a small table, pages and tasks mostly from pools
  task automatic test_random_mix(input int count, input int size, input bit no_idle);
    int                  pick;
    logic [OPCODE_W-1:0] op;
    logic [PAGE_W-1:0]   page;
    logic [TID_W-1:0]    tid;
    logic [SIDX_W-1:0]   sidx;
    steady = no_idle;
    write_partition_size(size);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      op = OP_ALLOC;
      else if (pick < 70) op = OP_PULL;
      else if (pick < 88) op = OP_FREE;
      else                op = OP_CLEAN;
      if ($urandom_range(0, 99) < 80) page = page_pool[$urandom_range(0, 15)];
      else                            page = PAGE_W'($urandom());
      if ($urandom_range(0, 99) < 85) tid = task_pool[$urandom_range(0, 5)];
      else                            tid = TID_W'($urandom());
      if ($urandom_range(0, 99) < 80) sidx = SIDX_W'($urandom_range(0, made_count + 1));
      else                            sidx = SIDX_W'($urandom());
      issue_request(op, page, tid, sidx);
    end
    steady = 1'b0;
  endtask

  // Fill a large part of the table, then long scans, idle frees and size extremes
  task automatic test_large_table();
    write_partition_size(8192);
    for (int n = 0; n < LARGE_FILL; n++) begin
      issue_request(OP_ALLOC, {1'b1, n[PAGE_W-2:0]}, n[0] ? 16'hFFFF : 16'h1234, '0);
    end
    issue_request(OP_PULL,  {1'b1, 19'(LARGE_FILL - 1)}, '0, '0);
    issue_request(OP_PULL,  20'h7FFFF, '0, '0);
    issue_request(OP_FREE,  '0, '0, 10'h3FF);
    issue_request(OP_ALLOC, 20'hABCDE, 16'h4321, '0);
    issue_request(OP_CLEAN, '0, 16'hFFFF, '0);
    issue_request(OP_ALLOC, 20'h0F0F0, 16'h0001, '0);
    write_partition_size(16383);
    issue_request(OP_ALLOC, 20'h00F0F, 16'h0002, '0);
    write_partition_size(0);
    issue_request(OP_ALLOC, 20'h55555, 16'h0003, '0);
  endtask

  // Result side: random back-pressure
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 9);
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result: op_ok=%0d sector=%0d", op_ok, sector);
      end else begin
        want = awaited_outcomes.pop_front();
        if (op_ok !== want.ok || sector !== want.sector) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch: expected op_ok=%0d sector=%0d, got op_ok=%0d sector=%0d",
                     want.ok, want.sector, op_ok, sector);
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("swap_slot_allocator_core_test: FAIL");
      $finish;
    end
  end

  // Test sequence
  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) held[i] = 1'b0;
    page_pool[0] = '0;
    page_pool[1] = '1;
    for (int i = 2; i < 16; i++) page_pool[i] = PAGE_W'($urandom());
    task_pool[0] = '0;
    task_pool[1] = '1;
    for (int i = 2; i < 6; i++) task_pool[i] = TID_W'($urandom());
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_empty_partition();
    test_directed_ops();
    test_random_mix(120, 96, 1'b0);
    test_random_mix(100, 400, 1'b1);
    test_random_mix(120, 16, 1'b0);  // below the created count: stack only
    test_large_table();

    in_valid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && awaited_outcomes.size() == 0) begin
      $display("swap_slot_allocator_core_test: PASS");
    end else begin
      $display("swap_slot_allocator_core_test: FAIL");
    end
    $finish;
  end

endmodule
